// ===== rtl/mfmd_pkg.sv =====
// shared types and constants for the media format magic detector
// no dependencies
`default_nettype none

package mfmd_pkg;

  localparam int HDR_LEN         = 12;
  localparam int TAG_BITS        = 29;
  localparam int TS_PROBE_OFFSET = 188;
  localparam int COUNT_BITS      = 29;
  localparam int QUEUE_DEPTH     = 2;
  localparam int QPTR_BITS       = $clog2(QUEUE_DEPTH);
  localparam logic [3:0] GROUP_EN_RESET = 4'hF;

  localparam int GRP_CONTAINERS = 0;
  localparam int GRP_AUDIO      = 1;
  localparam int GRP_IMAGES     = 2;
  localparam int GRP_VIDEO      = 3;

  typedef logic [HDR_LEN-1:0][7:0] hdr_t;

  // finished buffer as handed from capture to classification
  typedef struct packed {
    hdr_t hdr;
    logic ge4;
    logic ge5;
    logic ge8;
    logic ge12;
    logic probe_ok;
    logic flac_tag;
  } snap_t;

  typedef enum logic [4:0] {
    FMT_UNKNOWN = 5'd0,
    FMT_MKV     = 5'd1,
    FMT_WEBM    = 5'd2,
    FMT_MOV     = 5'd3,
    FMT_MP4     = 5'd4,
    FMT_OGG     = 5'd5,
    FMT_AVI     = 5'd6,
    FMT_MPEG_PS = 5'd7,
    FMT_MPEG_TS = 5'd8,
    FMT_ASF     = 5'd9,
    FMT_FLV     = 5'd10,
    FMT_NUT     = 5'd11,
    FMT_FLAC    = 5'd12,
    FMT_WAV     = 5'd13,
    FMT_MP3     = 5'd14,
    FMT_M4A     = 5'd15,
    FMT_APE     = 5'd16,
    FMT_JPEG    = 5'd17,
    FMT_PNG     = 5'd18,
    FMT_WEBP    = 5'd19,
    FMT_BMP     = 5'd20,
    FMT_GIF     = 5'd21,
    FMT_TIFF    = 5'd22,
    FMT_ICO     = 5'd23,
    FMT_EXR     = 5'd24,
    FMT_ICNS    = 5'd25,
    FMT_HEIF    = 5'd26,
    FMT_H264    = 5'd27,
    FMT_H265    = 5'd28
  } fmt_t;

endpackage

`default_nettype wire

// ===== rtl/media_format_magic_detector.sv =====
// top level of the media format magic detector
// joins mfmd_front, mfmd_queue and mfmd_back; uses mfmd_pkg
`default_nettype none

// Takes one byte per clock while full is low and gives one format code per
// buffer, after the byte marked last. The capture registers update on each
// accepted byte, so a byte can be pushed in every cycle while full is low. A
// finished buffer goes to the queue, then its code to the result register. A
// two-entry queue of finished buffers sits between capture and classification,
// so results that are not popped only stop input once two more buffers have
// completed. group_enable resets to all groups on and is written with cfg_we.
module media_format_magic_detector
  import mfmd_pkg::*;
#(
  parameter int TS_PROBE_OFFSET = mfmd_pkg::TS_PROBE_OFFSET,
  parameter int COUNT_BITS      = mfmd_pkg::COUNT_BITS
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] data_byte,
  input  wire logic       last_byte,
  output logic            empty,
  input  wire logic       pop,
  output logic [4:0]      format_code,
  input  wire logic       cfg_we,
  input  wire logic [3:0] cfg_wdata
);

  logic [3:0] group_enable;
  logic       accept;
  logic       q_push, q_pop, q_empty;
  snap_t      front_snap, q_snap;

  assign accept = push && !full;
  assign q_push = accept && last_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      group_enable <= GROUP_EN_RESET;
    end else if (cfg_we) begin
      group_enable <= cfg_wdata;
    end
  end

  mfmd_front #(
    .TS_PROBE_OFFSET (TS_PROBE_OFFSET),
    .COUNT_BITS      (COUNT_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .snap      (front_snap)
  );

  mfmd_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (front_snap),
    .pop   (q_pop),
    .rdata (q_snap),
    .full  (full),
    .empty (q_empty)
  );

  mfmd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .snap         (q_snap),
    .snap_valid   (!q_empty),
    .snap_take    (q_pop),
    .group_enable (group_enable),
    .pop          (pop),
    .empty        (empty),
    .format_code  (format_code)
  );

`ifndef SYNTHESIS
  a_code_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> format_code <= FMT_H265)
    else $error("format code out of range");

  a_take_lands: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> !empty)
    else $error("classified item did not reach the result register");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> empty && !full && q_empty)
    else $error("queues not clear after reset");

  a_no_lost_item: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop && !q_empty |=> !q_empty)
    else $error("queued item dropped while result stalled");
`endif

endmodule

`default_nettype wire

// ===== rtl/mfmd_front.sv =====
// capture side: byte count, header bytes, probe byte and id3 tag tracking
// builds a snapshot on the final byte of a buffer; uses mfmd_pkg
`default_nettype none

module mfmd_front
  import mfmd_pkg::*;
#(
  parameter int TS_PROBE_OFFSET = mfmd_pkg::TS_PROBE_OFFSET,
  parameter int COUNT_BITS      = mfmd_pkg::COUNT_BITS
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic [7:0] data_byte,
  input  wire logic       last_byte,
  output snap_t           snap
);

  localparam int CW = COUNT_BITS + 1;

  logic [COUNT_BITS-1:0] byte_count, byte_count_next;
  hdr_t                  header_bytes, header_bytes_next;
  logic [7:0]            probe_byte, probe_byte_next;
  logic [TAG_BITS-1:0]   tag_skip_offset, tag_skip_offset_next;
  logic [31:0]           after_tag_word, after_tag_word_next;

  logic                  id3_ok;
  logic [27:0]           id3_size;
  logic [TAG_BITS-1:0]   id3_len;
  logic [CW-1:0]         idx_ext, tso_ext, n_ext, diff;
  logic                  in_window;

  always_comb begin
    header_bytes_next = header_bytes;
    for (int i = 0; i < HDR_LEN; i++) begin
      if (byte_count == COUNT_BITS'(i)) begin
        header_bytes_next[i] = data_byte;
      end
    end

    id3_ok = header_bytes_next[0] == "I" && header_bytes_next[1] == "D" &&
             header_bytes_next[2] == "3" && header_bytes_next[3] != 8'hFF &&
             header_bytes_next[4] != 8'hFF &&
             ((header_bytes_next[6] | header_bytes_next[7] |
               header_bytes_next[8] | header_bytes_next[9]) & 8'h80) == 8'h00;
    id3_size = {header_bytes_next[6][6:0], header_bytes_next[7][6:0],
                header_bytes_next[8][6:0], header_bytes_next[9][6:0]};
    id3_len  = TAG_BITS'(id3_size) + TAG_BITS'(10) +
               (header_bytes_next[5][4] ? TAG_BITS'(10) : '0);

    tag_skip_offset_next = tag_skip_offset;
    if (byte_count == COUNT_BITS'(9)) begin
      tag_skip_offset_next = id3_ok ? id3_len : '0;
    end

    idx_ext   = CW'(byte_count);
    tso_ext   = CW'(tag_skip_offset_next);
    diff      = idx_ext - tso_ext;
    in_window = tag_skip_offset_next != '0 && idx_ext >= tso_ext && diff < CW'(4);

    after_tag_word_next = after_tag_word;
    if (in_window) begin
      after_tag_word_next = after_tag_word | (32'(data_byte) << {diff[1:0], 3'b000});
    end

    probe_byte_next = (byte_count == COUNT_BITS'(TS_PROBE_OFFSET)) ? data_byte
                                                                   : probe_byte;
    byte_count_next = (byte_count == '1) ? byte_count : byte_count + 1'b1;
    n_ext           = CW'(byte_count_next);

    snap.hdr      = header_bytes_next;
    snap.ge4      = n_ext >= CW'(4);
    snap.ge5      = n_ext >= CW'(5);
    snap.ge8      = n_ext >= CW'(8);
    snap.ge12     = n_ext >= CW'(12);
    snap.probe_ok = n_ext >= CW'(TS_PROBE_OFFSET + 1) && probe_byte_next == 8'h47;
    snap.flac_tag = tag_skip_offset_next != '0 && tso_ext + CW'(4) <= n_ext &&
                    after_tag_word_next == 32'h43614C66;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count      <= '0;
      header_bytes    <= '0;
      probe_byte      <= '0;
      tag_skip_offset <= '0;
      after_tag_word  <= '0;
    end else if (accept) begin
      if (last_byte) begin
        byte_count      <= '0;
        header_bytes    <= '0;
        probe_byte      <= '0;
        tag_skip_offset <= '0;
        after_tag_word  <= '0;
      end else begin
        byte_count      <= byte_count_next;
        header_bytes    <= header_bytes_next;
        probe_byte      <= probe_byte_next;
        tag_skip_offset <= tag_skip_offset_next;
        after_tag_word  <= after_tag_word_next;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mfmd_queue.sv =====
// short queue of finished buffer snapshots between capture and classification
// uses mfmd_pkg
`default_nettype none

module mfmd_queue
  import mfmd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire snap_t wdata,
  input  wire logic  pop,
  output snap_t      rdata,
  output logic       full,
  output logic       empty
);

  snap_t                mem [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [QPTR_BITS:0]   count;

  assign full  = count == (QPTR_BITS + 1)'(QUEUE_DEPTH);
  assign empty = count == '0;
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mfmd_back.sv =====
// classification side: detector groups in fixed order and the result register
// uses mfmd_pkg
`default_nettype none

module mfmd_back
  import mfmd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire snap_t      snap,
  input  wire logic       snap_valid,
  output logic            snap_take,
  input  wire logic [3:0] group_enable,
  input  wire logic       pop,
  output logic            empty,
  output logic [4:0]      format_code
);

  function automatic logic m4(hdr_t h, int off, logic [31:0] s);
    return {h[off], h[off+1], h[off+2], h[off+3]} == s;
  endfunction

  function automatic fmt_t det_containers(snap_t s);
    logic ftyp;
    ftyp = s.ge8 && m4(s.hdr, 4, "ftyp");
    if (m4(s.hdr, 0, 32'h1A45DFA3)) return FMT_MKV;
    if (ftyp) begin
      if (s.ge12 && m4(s.hdr, 8, "webm")) return FMT_WEBM;
      if (s.ge12 && m4(s.hdr, 8, "qt  ")) return FMT_MOV;
      return FMT_MP4;
    end
    if (m4(s.hdr, 0, "OggS")) return FMT_OGG;
    if (m4(s.hdr, 0, "RIFF") && s.ge12 && m4(s.hdr, 8, "AVI ")) return FMT_AVI;
    if (m4(s.hdr, 0, 32'h000001BA)) return FMT_MPEG_PS;
    if (s.hdr[0] == 8'h47 && s.probe_ok) return FMT_MPEG_TS;
    if (m4(s.hdr, 0, 32'h3026B275)) return FMT_ASF;
    if (m4(s.hdr, 0, 32'h464C5601)) return FMT_FLV;
    if (m4(s.hdr, 0, "NUTS")) return FMT_NUT;
    return FMT_UNKNOWN;
  endfunction

  function automatic fmt_t det_audio(snap_t s);
    if (m4(s.hdr, 0, "fLaC")) return FMT_FLAC;
    if (m4(s.hdr, 0, "RIFF") && s.ge12 && m4(s.hdr, 8, "WAVE")) return FMT_WAV;
    if (s.hdr[0] == "I" && s.hdr[1] == "D" && s.hdr[2] == "3") begin
      return s.flac_tag ? FMT_FLAC : FMT_MP3;
    end
    if (s.hdr[0] == 8'hFF && s.hdr[1][7:1] == 7'h7D) return FMT_MP3;
    if (s.ge12 && m4(s.hdr, 4, "ftyp") && m4(s.hdr, 8, "M4A ")) return FMT_M4A;
    if (m4(s.hdr, 0, "Mac ")) return FMT_APE;
    return FMT_UNKNOWN;
  endfunction

  function automatic fmt_t det_images(snap_t s);
    if (s.hdr[0] == 8'hFF && s.hdr[1] == 8'hD8 && s.hdr[2] == 8'hFF) return FMT_JPEG;
    if (m4(s.hdr, 0, 32'h89504E47)) return FMT_PNG;
    if (m4(s.hdr, 0, "RIFF") && s.ge12 && m4(s.hdr, 8, "WEBP")) return FMT_WEBP;
    if (s.hdr[0] == "B" && s.hdr[1] == "M") return FMT_BMP;
    if (m4(s.hdr, 0, "GIF8")) return FMT_GIF;
    if (m4(s.hdr, 0, 32'h49492A00) || m4(s.hdr, 0, 32'h4D4D002A)) return FMT_TIFF;
    if (m4(s.hdr, 0, 32'h00000100)) return FMT_ICO;
    if (m4(s.hdr, 0, 32'h762F3101)) return FMT_EXR;
    if (m4(s.hdr, 0, "icns")) return FMT_ICNS;
    if (s.ge12 && m4(s.hdr, 4, "ftyp") &&
        (m4(s.hdr, 8, "avif") || m4(s.hdr, 8, "heic") || m4(s.hdr, 8, "hevc"))) begin
      return FMT_HEIF;
    end
    return FMT_UNKNOWN;
  endfunction

  function automatic fmt_t det_video(snap_t s);
    logic [7:0] nal;
    if (m4(s.hdr, 0, 32'h00000001)) begin
      if (!s.ge5) return FMT_UNKNOWN;
      nal = s.hdr[4];
    end else if (s.hdr[0] == 8'h00 && s.hdr[1] == 8'h00 && s.hdr[2] == 8'h01) begin
      nal = s.hdr[3];
    end else begin
      return FMT_UNKNOWN;
    end
    if (nal[4:0] == 5'd7) return FMT_H264;
    if (nal[6:1] == 6'd32) return FMT_H265;
    return FMT_UNKNOWN;
  endfunction

  fmt_t code_next, code;
  logic out_valid;

  always_comb begin
    code_next = FMT_UNKNOWN;
    if (snap.ge4) begin
      if (group_enable[GRP_CONTAINERS]) code_next = det_containers(snap);
      if (code_next == FMT_UNKNOWN && group_enable[GRP_AUDIO]) code_next = det_audio(snap);
      if (code_next == FMT_UNKNOWN && group_enable[GRP_IMAGES]) code_next = det_images(snap);
      if (code_next == FMT_UNKNOWN && group_enable[GRP_VIDEO]) code_next = det_video(snap);
    end
  end

  assign snap_take   = snap_valid && (!out_valid || pop);
  assign empty       = !out_valid;
  assign format_code = code;

  always_ff @(posedge clk) begin
    if (snap_take) begin
      code <= code_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (snap_take) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/media_format_magic_detector_tb.sv =====
`timescale 1ns / 100ps
// testbench for media_format_magic_detector: streams byte buffers with random gaps
// and result stalls, predicts each format code and checks the codes in order
// depends on mfmd_pkg and the detector rtl
module media_format_magic_detector_tb;
  import mfmd_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 8;
  localparam int TOTAL_BYTES = 1400;
  localparam int PHASE_BYTES = 90;
  localparam int MAX_PRINTS = 20;
  localparam longint COUNT_MAX = (longint'(1) << COUNT_BITS) - 1;

  typedef enum int {
    KIND_NOISE, KIND_MKV, KIND_FTYP, KIND_OGG, KIND_RIFF, KIND_PS, KIND_TS, KIND_ASF,
    KIND_FLV, KIND_NUT, KIND_FLAC, KIND_ID3, KIND_MP3, KIND_APE, KIND_JPEG, KIND_PNG,
    KIND_BMP, KIND_GIF, KIND_TIFF, KIND_ICO, KIND_EXR, KIND_ICNS, KIND_NAL4, KIND_NAL3
  } frame_kind_e;

  typedef struct packed {
    logic [7:0] data;
    logic fin;
  } stream_byte_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic [7:0] data_byte = 8'h00;
  logic last_byte = 1'b0;
  logic empty;
  logic pop = 1'b0;
  logic [4:0] format_code;
  logic cfg_we = 1'b0;
  logic [3:0] cfg_wdata = GROUP_EN_RESET;

  stream_byte_t bytes_to_send[$];
  fmt_t codes_due[$];
  logic [7:0] frame_bytes[$];
  fmt_t due_code;

  // predictor state
  logic [3:0] group_en = GROUP_EN_RESET;
  longint seen_count = 0;
  logic [7:0] hdr_seen[HDR_LEN] = '{default: 8'h00};
  logic [7:0] ts_probe = 8'h00;
  longint tag_len = 0;
  logic [31:0] tag_word = 32'h0;

  int burst_left = 1;
  int idle_left = 0;
  int stall_left = 0;
  int recv_tick = 0;
  int mismatch_count = 0;
  int codes_checked = 0;
  int frames_queued = 0;
  int bytes_queued = 0;
  int full_waits = 0;

  media_format_magic_detector u_top (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .data_byte(data_byte),
    .last_byte(last_byte),
    .empty(empty),
    .pop(pop),
    .format_code(format_code),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("status: fail");
    $finish;
  end

  task automatic report_mismatch(string what, logic [4:0] got, logic [4:0] want);
    if (mismatch_count < MAX_PRINTS) begin
      $display("mismatch: %s got %0d want %0d at %0t", what, got, want, $realtime);
    end
    mismatch_count++;
  endtask

  function automatic bit at4(int off, logic [31:0] w);
    return {hdr_seen[off], hdr_seen[off + 1], hdr_seen[off + 2], hdr_seen[off + 3]} == w;
  endfunction

  function automatic fmt_t classify_buffer();
    longint n;
    fmt_t code;
    logic [7:0] nal;
    bit ftyp;
    bit nal_ok;
    n = seen_count;
    code = FMT_UNKNOWN;
    ftyp = n >= 8 && at4(4, "ftyp");
    if (n < 4) return FMT_UNKNOWN;
    if (group_en[GRP_CONTAINERS]) begin
      if (at4(0, 32'h1A45DFA3)) code = FMT_MKV;
      else if (ftyp) begin
        if (n >= 12 && at4(8, "webm")) code = FMT_WEBM;
        else if (n >= 12 && at4(8, "qt  ")) code = FMT_MOV;
        else code = FMT_MP4;
      end
      else if (at4(0, "OggS")) code = FMT_OGG;
      else if (at4(0, "RIFF") && n >= 12 && at4(8, "AVI ")) code = FMT_AVI;
      else if (at4(0, 32'h000001BA)) code = FMT_MPEG_PS;
      else if (hdr_seen[0] == 8'h47 && n >= TS_PROBE_OFFSET + 1 && ts_probe == 8'h47)
        code = FMT_MPEG_TS;
      else if (at4(0, 32'h3026B275)) code = FMT_ASF;
      else if (at4(0, {"FLV", 8'h01})) code = FMT_FLV;
      else if (at4(0, "NUTS")) code = FMT_NUT;
    end
    if (code == FMT_UNKNOWN && group_en[GRP_AUDIO]) begin
      if (at4(0, "fLaC")) code = FMT_FLAC;
      else if (at4(0, "RIFF") && n >= 12 && at4(8, "WAVE")) code = FMT_WAV;
      else if (hdr_seen[0] == "I" && hdr_seen[1] == "D" && hdr_seen[2] == "3") begin
        // fLaC read as a little-endian word
        if (tag_len > 0 && tag_len + 4 <= n && tag_word == 32'h43614C66) code = FMT_FLAC;
        else code = FMT_MP3;
      end
      else if (hdr_seen[0] == 8'hFF && hdr_seen[1][7:1] == 7'h7D) code = FMT_MP3;
      else if (ftyp && n >= 12 && at4(8, "M4A ")) code = FMT_M4A;
      else if (at4(0, "Mac ")) code = FMT_APE;
    end
    if (code == FMT_UNKNOWN && group_en[GRP_IMAGES]) begin
      if (hdr_seen[0] == 8'hFF && hdr_seen[1] == 8'hD8 && hdr_seen[2] == 8'hFF) code = FMT_JPEG;
      else if (at4(0, {8'h89, "PNG"})) code = FMT_PNG;
      else if (at4(0, "RIFF") && n >= 12 && at4(8, "WEBP")) code = FMT_WEBP;
      else if (hdr_seen[0] == "B" && hdr_seen[1] == "M") code = FMT_BMP;
      else if (at4(0, "GIF8")) code = FMT_GIF;
      else if (at4(0, 32'h49492A00) || at4(0, 32'h4D4D002A)) code = FMT_TIFF;
      else if (at4(0, 32'h00000100)) code = FMT_ICO;
      else if (at4(0, 32'h762F3101)) code = FMT_EXR;
      else if (at4(0, "icns")) code = FMT_ICNS;
      else if (n >= 12 && at4(4, "ftyp") &&
               (at4(8, "avif") || at4(8, "heic") || at4(8, "hevc"))) code = FMT_HEIF;
    end
    if (code == FMT_UNKNOWN && group_en[GRP_VIDEO]) begin
      nal = 8'h00;
      nal_ok = 1'b0;
      if (at4(0, 32'h00000001)) begin
        nal_ok = n >= 5;
        nal = hdr_seen[4];
      end else if (hdr_seen[0] == 8'h00 && hdr_seen[1] == 8'h00 && hdr_seen[2] == 8'h01) begin
        nal_ok = 1'b1;
        nal = hdr_seen[3];
      end
      if (nal_ok && nal[4:0] == 5'd7) code = FMT_H264;
      else if (nal_ok && nal[6:1] == 6'd32) code = FMT_H265;
    end
    return code;
  endfunction

  task automatic absorb_byte(logic [7:0] b, logic fin);
    longint idx;
    idx = seen_count;
    if (idx < HDR_LEN) hdr_seen[idx] = b;
    if (idx == TS_PROBE_OFFSET) ts_probe = b;
    if (idx == 9) begin
      tag_len = 0;
      if (hdr_seen[0] == "I" && hdr_seen[1] == "D" && hdr_seen[2] == "3" &&
          hdr_seen[3] != 8'hFF && hdr_seen[4] != 8'hFF &&
          ((hdr_seen[6] | hdr_seen[7] | hdr_seen[8] | hdr_seen[9]) & 8'h80) == 8'h00) begin
        tag_len = ((longint'(hdr_seen[6][6:0]) << 21) | (longint'(hdr_seen[7][6:0]) << 14) |
                   (longint'(hdr_seen[8][6:0]) << 7) | longint'(hdr_seen[9][6:0])) + 10;
        if (hdr_seen[5][4]) tag_len += 10;
      end
    end
    if (tag_len > 0 && idx >= tag_len && idx < tag_len + 4)
      tag_word |= 32'(b) << (8 * (idx - tag_len));
    if (idx < COUNT_MAX) seen_count = idx + 1;
    if (fin) begin
      codes_due.insert(codes_due.size(), classify_buffer());
      seen_count = 0;
      foreach (hdr_seen[i]) hdr_seen[i] = 8'h00;
      ts_probe = 8'h00;
      tag_len = 0;
      tag_word = 32'h0;
    end
  endtask

  task automatic append_byte(logic [7:0] b);
    frame_bytes.insert(frame_bytes.size(), b);
  endtask

  task automatic add_rand(int k);
    repeat (k) append_byte(8'($urandom));
  endtask

  task automatic add4(logic [31:0] w);
    append_byte(w[31:24]);
    append_byte(w[23:16]);
    append_byte(w[15:8]);
    append_byte(w[7:0]);
  endtask

  // len 0 picks a length around the magic, clean keeps the magic well formed
  task automatic queue_frame(frame_kind_e kind, int len, bit clean);
    int need;
    int pos;
    int id3_hi;
    logic [7:0] id3_lo;
    logic [7:0] flags;
    logic [7:0] nal;
    stream_byte_t sb;
    frame_bytes = {};
    if (!clean) nal = 8'($urandom);
    else if ($urandom_range(0, 1) == 0) nal = {3'($urandom), 5'd7};
    else nal = {1'($urandom), 6'd32, 1'($urandom)};
    case (kind)
      KIND_MKV: add4(32'h1A45DFA3);
      KIND_FTYP: begin
        add_rand(4);
        add4("ftyp");
        case ($urandom_range(0, 6))
          0: add4("webm");
          1: add4("qt  ");
          2: add4("M4A ");
          3: add4("avif");
          4: add4("heic");
          5: add4("hevc");
          default: add_rand(4);
        endcase
      end
      KIND_OGG: add4("OggS");
      KIND_RIFF: begin
        add4("RIFF");
        add_rand(4);
        case ($urandom_range(0, 3))
          0: add4("AVI ");
          1: add4("WAVE");
          2: add4("WEBP");
          default: add_rand(4);
        endcase
      end
      KIND_PS: add4(32'h000001BA);
      KIND_TS: begin
        append_byte(8'h47);
        add_rand(TS_PROBE_OFFSET - 1);
        append_byte((clean || $urandom_range(0, 1) == 0) ? 8'h47 : 8'($urandom));
      end
      KIND_ASF: add4(32'h3026B275);
      KIND_FLV: add4({"FLV", 8'h01});
      KIND_NUT: add4("NUTS");
      KIND_FLAC: add4("fLaC");
      KIND_ID3: begin
        flags = 8'($urandom);
        id3_hi = (!clean && $urandom_range(0, 7) == 0) ? 1 : 0;
        id3_lo = 8'($urandom_range(0, 30));
        if (!clean && $urandom_range(0, 4) == 0) id3_lo[7] = 1'b1;
        add4({"ID3", (!clean && $urandom_range(0, 4) == 0) ? 8'hFF : 8'h03});
        append_byte((!clean && $urandom_range(0, 4) == 0) ? 8'hFF : 8'h00);
        append_byte(flags);
        append_byte((!clean && $urandom_range(0, 9) == 0) ? 8'($urandom) : 8'h00);
        append_byte((!clean && $urandom_range(0, 9) == 0) ? 8'($urandom) : 8'h00);
        append_byte(8'(id3_hi));
        append_byte(id3_lo);
        add_rand(id3_hi * 128 + int'(id3_lo[6:0]) + (flags[4] ? 10 : 0));
        add4((clean || $urandom_range(0, 1) == 0) ? "fLaC" : 32'($urandom));
      end
      KIND_MP3: begin
        append_byte(8'hFF);
        append_byte(clean ? {7'h7D, 1'($urandom)} : 8'($urandom));
        add_rand(2);
      end
      KIND_APE: add4("Mac ");
      KIND_JPEG: add4({16'hFFD8, 8'hFF, 8'($urandom)});
      KIND_PNG: add4({8'h89, "PNG"});
      KIND_BMP: add4({"BM", 16'($urandom)});
      KIND_GIF: add4("GIF8");
      KIND_TIFF: add4(($urandom_range(0, 1) == 0) ? 32'h49492A00 : 32'h4D4D002A);
      KIND_ICO: add4(32'h00000100);
      KIND_EXR: add4(32'h762F3101);
      KIND_ICNS: add4("icns");
      KIND_NAL4: begin
        add4(32'h00000001);
        append_byte(nal);
      end
      KIND_NAL3: add4({24'h000001, nal});
      default: add_rand($urandom_range(1, 12));
    endcase
    need = frame_bytes.size();
    if (len == 0) begin
      if (!clean && $urandom_range(0, 2) == 0) len = $urandom_range(1, need);
      else len = need + $urandom_range(0, 6);
    end
    while (frame_bytes.size() > len) void'(frame_bytes.pop_back());
    if (frame_bytes.size() < len) add_rand(len - frame_bytes.size());
    if (!clean && $urandom_range(0, 3) == 0) begin
      pos = $urandom_range(0, len - 1);
      frame_bytes[pos] = frame_bytes[pos] ^ 8'(1 << $urandom_range(0, 7));
    end
    foreach (frame_bytes[i]) begin
      sb.data = frame_bytes[i];
      sb.fin = (i == len - 1);
      bytes_to_send.insert(bytes_to_send.size(), sb);
    end
    frames_queued++;
    bytes_queued += len;
  endtask

  task automatic drain();
    while (bytes_to_send.size() != 0 || codes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // sender: bursts of random length with random gaps between them
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        absorb_byte(bytes_to_send[0].data, bytes_to_send[0].fin);
        void'(bytes_to_send.pop_front());
      end
      if (push && full) begin
        full_waits++;
      end else if (bytes_to_send.size() == 0) begin
        push <= 1'b0;
      end else if (idle_left != 0) begin
        push <= 1'b0;
        idle_left--;
      end else begin
        push <= 1'b1;
        data_byte <= bytes_to_send[0].data;
        last_byte <= bytes_to_send[0].fin;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(64, 256) : $urandom_range(1, 16);
          idle_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  // receiver: checks each popped code and stalls on its own pattern
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (codes_due.size() == 0) begin
          report_mismatch("format_code with no buffer pending", format_code, FMT_UNKNOWN);
        end else begin
          due_code = codes_due.pop_front();
          if (format_code !== due_code) report_mismatch("format_code", format_code, due_code);
          codes_checked++;
        end
      end
      recv_tick++;
      if (stall_left != 0) begin
        pop <= 1'b0;
        stall_left--;
      end else begin
        pop <= 1'b1;
        if (recv_tick[9:8] != 2'd0 && $urandom_range(0, 5) == 0)
          stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 48) : $urandom_range(1, 6);
      end
    end
  end

  initial begin
    logic [3:0] plan[9];
    frame_kind_e kind;
    int goal;
    plan = '{4'hF, 4'h0, 4'h1, 4'h2, 4'h4, 4'h8, 4'($urandom), 4'($urandom), 4'hF};
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // short buffers, missing nal byte, id3 followed by flac, mp3 sync, ts probe
    queue_frame(KIND_NOISE, 1, 1'b1);
    queue_frame(KIND_NOISE, 2, 1'b1);
    queue_frame(KIND_NOISE, 3, 1'b1);
    queue_frame(KIND_NAL4, 4, 1'b1);
    queue_frame(KIND_NAL4, 5, 1'b1);
    queue_frame(KIND_NAL3, 4, 1'b1);
    queue_frame(KIND_ID3, 0, 1'b1);
    queue_frame(KIND_MP3, 4, 1'b1);
    queue_frame(KIND_MP3, 4, 1'b1);
    queue_frame(KIND_FTYP, 8, 1'b1);
    queue_frame(KIND_FTYP, 11, 1'b1);
    queue_frame(KIND_TS, TS_PROBE_OFFSET + 1, 1'b1);
    queue_frame(KIND_TS, TS_PROBE_OFFSET, 1'b1);
    goal = bytes_queued;

    foreach (plan[p]) begin
      drain();
      cfg_we <= 1'b1;
      cfg_wdata <= plan[p];
      group_en = plan[p];
      @(posedge clk);
      cfg_we <= 1'b0;
      goal = (p == 8) ? TOTAL_BYTES : goal + PHASE_BYTES;
      while (bytes_queued < goal) begin
        kind = frame_kind_e'($urandom_range(0, int'(KIND_NAL3)));
        if (kind == KIND_TS && $urandom_range(0, 7) != 0) kind = KIND_NOISE;
        queue_frame(kind, 0, $urandom_range(0, 3) != 0);
      end
    end
    drain();

    $display("covered %0d buffers, %0d bytes, %0d codes checked over %0d enable settings",
             frames_queued, bytes_queued, codes_checked, 9);
    $display("input held back by full on %0d cycles", full_waits);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
